// ===== design/page_free_list_allocator_macros.svh =====
// Assertion macros used by the allocator checker.
`ifndef PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define PFLA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Check cons in the cycle after ante.
`define PFLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== design/pfla_pkg.sv =====
// Package with widths and codes of the page free-list allocator.
package pfla_pkg;

    localparam int ADDR_W = 39;
    localparam int PAGE_W = 27;

    typedef logic [1:0] req_t;
    typedef logic [1:0] status_t;

    localparam req_t REQ_INIT  = 2'd0;
    localparam req_t REQ_FREE  = 2'd1;
    localparam req_t REQ_ALLOC = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_OOM      = 2'd1;
    localparam status_t ST_BAD_FREE = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

endpackage

// ===== design/page_free_list_allocator.sv =====
// Top level of the page free-list allocator: LIFO stack of page numbers in one memory.
// Free and no-op items pass from acceptance through S_FIN to the result, alloc items through
// S_RD and S_FIN (registered read of the stack memory); one item is in work at a time.
// Init writes one page per cycle into the stack memory, min(pages, POOL_PAGES) pages in all.
// Reset (rst_n, asynchronous, active low) empties the stack and loads the default region;
// the stack memory itself is not cleared.
module page_free_list_allocator
    import pfla_pkg::*;
#(
    parameter int POOL_PAGES = 32768,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [PAGE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // [38:0] page_address, [39] zero
    input  logic [1:0]        s_tuser,   // [1:0] req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // [38:0] granted_address, [39] zero
    output logic [1:0]        m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(POOL_PAGES + 1);
    localparam int IDX_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam logic [PAGE_W-1:0] POOL_P = PAGE_W'(POOL_PAGES);
    localparam logic [CNT_W-1:0] POOL_C = CNT_W'(POOL_PAGES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INIT = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_END   = 1'b1;

    logic [PAGE_W-1:0] stack_mem [POOL_PAGES];

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PAGE_W-1:0] first_reg, end_reg;
    logic [PAGE_W-1:0] init_page_reg, init_page_next;
    logic [CNT_W-1:0]  init_left_reg, init_left_next;
    status_t           res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_grant_reg, res_grant_next;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ADDR_W-1:0] out_grant_reg;
    logic [PAGE_W-1:0] rd_data_reg;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [PAGE_W-1:0] mem_wdata;

    logic              in_take, out_free;
    req_t              req;
    logic [ADDR_W-1:0] addr;
    logic [PAGE_W-1:0] free_page, span;
    logic              bad_free;
    logic [CNT_W-1:0]  take, count_dec;

    assign s_tready = (state_reg == S_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign req      = s_tuser;
    assign addr     = s_tdata[ADDR_W-1:0];

    assign free_page = PAGE_W'(addr[ADDR_W-1:PAGE_SHIFT]);
    assign bad_free  = (addr[PAGE_SHIFT-1:0] != '0) || (free_page < first_reg)
                       || (free_page >= end_reg);
    assign span      = (end_reg > first_reg) ? (end_reg - first_reg) : '0;
    assign take      = (span > POOL_P) ? POOL_C : CNT_W'(span);
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        init_page_next  = init_page_reg;
        init_left_next  = init_left_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = init_page_reg;
        mem_re          = 1'b0;
        mem_raddr       = count_dec[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    res_status_next = ST_OK;
                    res_grant_next  = '0;
                    state_next      = S_FIN;
                    case (req)
                        REQ_INIT:
                        begin
                            count_next     = '0;
                            init_page_next = first_reg;
                            init_left_next = take;
                            if (span > POOL_P)
                            begin
                                res_status_next = ST_FULL;
                            end
                            if (take != '0)
                            begin
                                state_next = S_INIT;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (bad_free)
                            begin
                                res_status_next = ST_BAD_FREE;
                            end
                            else if (count_reg == POOL_C)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = free_page;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_OOM;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                count_next = count_dec;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                mem_we         = 1'b1;
                count_next     = count_reg + CNT_W'(1);
                init_page_next = init_page_reg + PAGE_W'(1);
                init_left_next = init_left_reg - CNT_W'(1);
                if (init_left_reg == CNT_W'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_RD:
            begin
                res_grant_next = ADDR_W'({rd_data_reg, {PAGE_SHIFT{1'b0}}});
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        init_page_reg  <= init_page_next;
        init_left_reg  <= init_left_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        if ((state_reg == S_FIN) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_grant_reg  <= res_grant_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            first_reg     <= PAGE_W'(524288);
            end_reg       <= PAGE_W'(557056);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we && (cfg_addr == CFG_FIRST))
            begin
                first_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == CFG_END))
            begin
                end_reg <= cfg_wdata;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_grant_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== design/pfla_checker.sv =====
// Port checker for the page free-list allocator and its bind.
`include "page_free_list_allocator_macros.svh"

module pfla_checker
    import pfla_pkg::*;
#(
    parameter int PAGE_SHIFT = 12
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `PFLA_ASSERT_SAME(a_fail_no_grant, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `PFLA_ASSERT_SAME(a_grant_aligned, m_tvalid, m_tdata[PAGE_SHIFT-1:0] == '0)
    `PFLA_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)
    `PFLA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind page_free_list_allocator pfla_checker #(.PAGE_SHIFT(PAGE_SHIFT)) u_pfla_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
